FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the game port block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: design/dgpm_pkg.sv
// Types and constants of the dual game port.
`timescale 1ns / 1ps

package dgpm_pkg;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ_A  = 2'd1,
    OP_READ_B  = 2'd2,
    OP_UPDATE  = 2'd3
  } op_t;

  // Device kind of a port; code 3 behaves as no device
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONE  = 2'd0;
  localparam kind_t KIND_PAD   = 2'd1;
  localparam kind_t KIND_MOUSE = 2'd2;

  // Boot override codes; code 3 is refused on write
  typedef logic [1:0] override_t;
  localparam override_t OVR_NONE  = 2'd0;
  localparam override_t OVR_PAD_A = 2'd1;
  localparam override_t OVR_PAD_B = 2'd2;
  localparam override_t OVR_BAD   = 2'd3;

  // Configuration register indexes (byte address 4*index)
  typedef enum logic [1:0] {
    REG_PORT_A_KIND   = 2'd0,
    REG_PORT_B_KIND   = 2'd1,
    REG_BOOT_OVERRIDE = 2'd2,
    REG_READ_TIMEOUT  = 2'd3
  } reg_idx_t;

  localparam logic [31:0] READ_TIMEOUT_RESET = 32'd1000000;

  // Fixed bytes returned under boot override
  localparam logic [7:0] BOOT_PAD_A_BYTE = 8'h2F;
  localparam logic [7:0] BOOT_PAD_B_BYTE = 8'h1F;

  // Gamepad byte: idle pattern and clearing masks
  localparam logic [7:0] COM_BIT      = 8'h40;
  localparam logic [7:0] PAD_IDLE     = 8'h3F;
  localparam logic [7:0] MASK_RUN     = 8'b11110011;
  localparam logic [7:0] MASK_RIGHT   = 8'hF7;
  localparam logic [7:0] MASK_LEFT    = 8'hFB;
  localparam logic [7:0] MASK_PAUSE   = 8'b11111100;
  localparam logic [7:0] MASK_DOWN    = 8'hFD;
  localparam logic [7:0] MASK_UP      = 8'hFE;
  localparam logic [7:0] MASK_BUTTON1 = 8'hEF;
  localparam logic [7:0] MASK_BUTTON2 = 8'hDF;

  // Per-port command strobes for one transaction
  typedef struct packed {
    logic write_en;
    logic com;
    logic read_en;
    logic update_en;
  } port_cmd_t;

endpackage

FILE: design/dgpm_port.sv
// One game port: COM line, controls, mouse phase and motion, read byte.
`timescale 1ns / 1ps

module dgpm_port #(
  parameter int TIME_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dgpm_pkg::kind_t        kind,
  input  logic [31:0]            read_timeout,
  input  dgpm_pkg::port_cmd_t    cmd,
  input  logic [TIME_BITS-1:0]   time_stamp,
  input  logic [7:0]             pad_bits,
  input  logic signed [7:0]      motion_x,
  input  logic signed [7:0]      motion_y,
  output logic [7:0]             read_data
);
  import dgpm_pkg::*;

  localparam int CmpBits = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [1:0]           mouse_phase;
  logic                 com_line;
  logic [7:0]           control_bits;
  logic [15:0]          live_motion;
  logic [15:0]          latched_motion;
  logic [TIME_BITS-1:0] previous_read_time;

  logic                 is_mouse;
  logic                 is_pad;
  logic [TIME_BITS-1:0] gap;
  logic                 timed_out;
  logic [1:0]           read_phase;
  logic [1:0]           write_phase;
  logic [3:0]           nibble;
  logic [7:0]           pad_byte;

  assign is_mouse = (kind == KIND_MOUSE);
  assign is_pad   = (kind == KIND_PAD);

  // Reset the phase when the gap since the last read exceeds the timeout
  assign gap        = time_stamp - previous_read_time;
  assign timed_out  = (time_stamp >= previous_read_time) &&
                      (CmpBits'(gap) > CmpBits'(read_timeout));
  assign read_phase = (is_mouse && timed_out) ? 2'd0 : mouse_phase;

  // Step the phase on COM written low in even phases, COM high in odd phases
  always_comb begin
    write_phase = mouse_phase;
    if (is_mouse && (mouse_phase[0] == cmd.com)) begin
      write_phase = mouse_phase + 2'd1;
    end
  end

  // Pick the motion nibble; phase 0 reads the live motion as it latches
  always_comb begin
    case (read_phase)
      2'd0:    nibble = live_motion[7:4];
      2'd1:    nibble = latched_motion[3:0];
      2'd2:    nibble = latched_motion[15:12];
      2'd3:    nibble = latched_motion[11:8];
      default: nibble = latched_motion[3:0];
    endcase
  end

  // Build the active-low gamepad byte
  always_comb begin
    pad_byte = PAD_IDLE;
    if (control_bits[4]) pad_byte = pad_byte & MASK_RUN;
    if (control_bits[3]) pad_byte = pad_byte & MASK_RIGHT;
    if (control_bits[2]) pad_byte = pad_byte & MASK_LEFT;
    if (control_bits[5]) pad_byte = pad_byte & MASK_PAUSE;
    if (control_bits[1]) pad_byte = pad_byte & MASK_DOWN;
    if (control_bits[0]) pad_byte = pad_byte & MASK_UP;
    if (control_bits[6]) pad_byte = pad_byte & MASK_BUTTON1;
    if (control_bits[7]) pad_byte = pad_byte & MASK_BUTTON2;
  end

  // Select the byte by device kind
  always_comb begin
    if (is_mouse) begin
      read_data = {1'b0, com_line, ~control_bits[7], ~control_bits[6], nibble};
    end else if (is_pad) begin
      read_data = pad_byte | (com_line ? COM_BIT : 8'h00);
    end else begin
      read_data = 8'h00;
    end
  end

  // Update the port state for the transaction in hand
  always_ff @(posedge clk) begin
    if (rst) begin
      mouse_phase        <= 2'd0;
      com_line           <= 1'b0;
      control_bits       <= 8'h00;
      live_motion        <= 16'h0000;
      latched_motion     <= 16'h0000;
      previous_read_time <= '0;
    end else begin
      if (cmd.write_en) begin
        mouse_phase <= write_phase;
        com_line    <= cmd.com;
      end
      if (cmd.read_en) begin
        previous_read_time <= time_stamp;
        if (is_mouse) begin
          mouse_phase <= read_phase;
          if (read_phase == 2'd0) begin
            latched_motion <= live_motion;
          end
          if (read_phase == 2'd3) begin
            live_motion <= 16'h0000;
          end
        end
      end
      if (cmd.update_en) begin
        control_bits <= pad_bits;
        live_motion  <= {motion_y, motion_x};
      end
    end
  end

endmodule

FILE: design/dual_game_port_mouse_pad_unit.sv
// Dual game port with gamepad and mouse devices. One transaction is taken per
// clock cycle while the input is not stalled: it is captured in an input
// register and applied to the port state when it advances from there, and a
// read places its byte in the output register at that same edge. The input
// side stalls only while a read sits in the input register behind a result the
// receiver has not yet taken; a held write or control update never stalls.
// There is no clearing pass after reset. Configuration is an APB register file
// at byte addresses 0, 4, 8 and 12: port A kind, port B kind, boot override and
// read timeout.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dual_game_port_mouse_pad_unit #(
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic                  port_select,
  input  logic [7:0]            write_data,
  input  logic [TIME_BITS-1:0]  time_stamp,
  input  logic [7:0]            pad_bits,
  input  logic signed [7:0]     motion_x,
  input  logic signed [7:0]     motion_y,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            read_data,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import dgpm_pkg::*;

  // Configuration registers
  kind_t       port_a_kind;
  kind_t       port_b_kind;
  override_t   boot_override;
  logic [31:0] read_timeout;
  logic        cfg_write;
  reg_idx_t    cfg_index;

  // Input register
  logic                  s1_valid;
  op_t                   s1_op;
  logic                  s1_port_select;
  logic [7:0]            s1_write_data;
  logic [TIME_BITS-1:0]  s1_time_stamp;
  logic [7:0]            s1_pad_bits;
  logic signed [7:0]     s1_motion_x;
  logic signed [7:0]     s1_motion_y;

  logic       s1_is_read;
  logic       out_free;
  logic       advance;
  logic       use_override;
  port_cmd_t  cmd_a;
  port_cmd_t  cmd_b;
  logic [7:0] data_a;
  logic [7:0] data_b;
  logic [7:0] result_byte;

  // Register file access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      port_a_kind   <= KIND_PAD;
      port_b_kind   <= KIND_MOUSE;
      boot_override <= OVR_NONE;
      read_timeout  <= READ_TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PORT_A_KIND: port_a_kind <= pwdata[1:0];
        REG_PORT_B_KIND: port_b_kind <= pwdata[1:0];
        REG_BOOT_OVERRIDE: begin
          if (pwdata[1:0] != OVR_BAD) begin
            boot_override <= pwdata[1:0];
          end
        end
        REG_READ_TIMEOUT: read_timeout <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_PORT_A_KIND:   prdata = {30'd0, port_a_kind};
      REG_PORT_B_KIND:   prdata = {30'd0, port_b_kind};
      REG_BOOT_OVERRIDE: prdata = {30'd0, boot_override};
      REG_READ_TIMEOUT:  prdata = read_timeout;
      default:           prdata = 32'd0;
    endcase
  end

  // Advance the held transaction unless a read waits on a full, stalled output register
  assign s1_is_read = (s1_op == OP_READ_A) || (s1_op == OP_READ_B);
  assign out_free   = !out_valid || !out_stall;
  assign advance    = s1_valid && (!s1_is_read || out_free);
  assign in_stall   = s1_valid && !advance;

  // Capture an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op          <= op_t'(operation);
      s1_port_select <= port_select;
      s1_write_data  <= write_data;
      s1_time_stamp  <= time_stamp;
      s1_pad_bits    <= pad_bits;
      s1_motion_x    <= motion_x;
      s1_motion_y    <= motion_y;
    end
  end

  // Decode per-port commands; an overridden port A read touches no state
  assign use_override = (boot_override == OVR_PAD_A) || (boot_override == OVR_PAD_B);

  always_comb begin
    cmd_a.write_en  = advance && (s1_op == OP_WRITE);
    cmd_a.com       = s1_write_data[4];
    cmd_a.read_en   = advance && (s1_op == OP_READ_A) && !use_override;
    cmd_a.update_en = advance && (s1_op == OP_UPDATE) && !s1_port_select;
    cmd_b.write_en  = advance && (s1_op == OP_WRITE);
    cmd_b.com       = s1_write_data[5];
    cmd_b.read_en   = advance && (s1_op == OP_READ_B);
    cmd_b.update_en = advance && (s1_op == OP_UPDATE) && s1_port_select;
  end

  dgpm_port #(
    .TIME_BITS (TIME_BITS)
  ) u_port_a (
    .clk          (clk),
    .rst          (rst),
    .kind         (port_a_kind),
    .read_timeout (read_timeout),
    .cmd          (cmd_a),
    .time_stamp   (s1_time_stamp),
    .pad_bits     (s1_pad_bits),
    .motion_x     (s1_motion_x),
    .motion_y     (s1_motion_y),
    .read_data    (data_a)
  );

  dgpm_port #(
    .TIME_BITS (TIME_BITS)
  ) u_port_b (
    .clk          (clk),
    .rst          (rst),
    .kind         (port_b_kind),
    .read_timeout (read_timeout),
    .cmd          (cmd_b),
    .time_stamp   (s1_time_stamp),
    .pad_bits     (s1_pad_bits),
    .motion_x     (s1_motion_x),
    .motion_y     (s1_motion_y),
    .read_data    (data_b)
  );

  // Choose the returned byte
  always_comb begin
    if (s1_op == OP_READ_B) begin
      result_byte = data_b;
    end else if (boot_override == OVR_PAD_A) begin
      result_byte = BOOT_PAD_A_BYTE;
    end else if (boot_override == OVR_PAD_B) begin
      result_byte = BOOT_PAD_B_BYTE;
    end else begin
      result_byte = data_a;
    end
  end

  // Load the output register on a read, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_is_read) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_is_read) begin
      read_data <= result_byte;
    end
  end

  // Design checks
  `ASSERT_CLK(a_stall_cause, in_stall |-> (s1_valid && s1_is_read && out_valid && out_stall), "input stalled without a blocked read")
  `ASSERT_CLK(a_read_result, (s1_valid && s1_is_read && !in_stall) |=> out_valid, "advanced read gave no result")
  `ASSERT_CLK(a_no_spurious, (!out_valid && !(s1_valid && s1_is_read)) |=> !out_valid, "result without a read")
  `ASSERT_CLK(a_boot_byte, (advance && (s1_op == OP_READ_A) && (boot_override == OVR_PAD_A)) |=> (read_data == BOOT_PAD_A_BYTE), "boot override byte wrong")

endmodule
